[sv/ccd_pkg.sv]
// Package for the Cyrillic code page detector: shared types, the letter pair
// table, the KOI8-R letter permutation and the pair index helpers.
// No dependencies; used by every module of the block.
package ccd_pkg;

  localparam int RowW  = 7;
  localparam int RowsN = 128;

  typedef logic [RowW-1:0] row_t;
  typedef logic [7:0]      bits_t;

  // Write request from the detector core into one seen-pair bitmap.
  typedef struct packed {
    logic  en;
    row_t  row;
    bits_t data;
  } bmp_wr_t;

  typedef enum logic [1:0] {
    CpAlt = 2'd0,
    CpWin = 2'd1,
    CpKoi = 2'd2
  } cp_e;

  localparam logic [15:0] ByteLimitReset = 16'd16384;
  localparam logic [7:0]  TotalMax       = 8'd255;

  // Letter pairs that occur in Russian, 32 rows of 32 bits, MSB first.
  localparam logic [7:0] PairOk [RowsN] = '{
    8'hFF,8'hFF,8'hFF,8'hC7,8'hFE,8'hBE,8'hF7,8'hFB,
    8'hFD,8'hBF,8'hF7,8'hF9,8'hFC,8'hBE,8'hF1,8'h80,
    8'hFF,8'hFF,8'hF7,8'hBB,8'hFF,8'hFF,8'hFF,8'hCF,
    8'hDE,8'hBF,8'hD1,8'h08,8'hFF,8'hBF,8'hF1,8'hBF,
    8'hFF,8'hFF,8'hFF,8'hC7,8'h1D,8'h3F,8'h7F,8'h81,
    8'hA7,8'hB6,8'hF2,8'h82,8'hFF,8'hFF,8'h75,8'hDB,
    8'hFC,8'hBF,8'hD7,8'h9D,8'hFF,8'hAE,8'hFB,8'hDF,
    8'hFF,8'hFF,8'hFF,8'hC7,8'h84,8'hB7,8'hF3,8'h9F,
    8'hFF,8'hFF,8'hFF,8'hDB,8'hFF,8'hBF,8'hFF,8'hFF,
    8'hFD,8'hBF,8'hFF,8'hFF,8'hFF,8'hFF,8'hE7,8'hC7,
    8'h84,8'h9E,8'hF0,8'h12,8'hBC,8'hBF,8'hF0,8'h84,
    8'hA4,8'hBA,8'h10,8'h10,8'hA4,8'hBE,8'hB8,8'h88,
    8'hAC,8'hBF,8'hF7,8'h0A,8'h84,8'h86,8'h90,8'h08,
    8'h04,8'h00,8'h00,8'h03,8'h7F,8'hFD,8'hF7,8'hC1,
    8'h7D,8'hAE,8'h6F,8'hCB,8'h15,8'h3D,8'hFC,8'h00,
    8'h7F,8'h7D,8'hE7,8'hC2,8'h7F,8'hFD,8'hF7,8'hC3
  };

  localparam logic [4:0] KoiLetter [32] = '{
    5'd30,5'd0, 5'd1, 5'd22,5'd4, 5'd5, 5'd20,5'd3,
    5'd21,5'd8, 5'd9, 5'd10,5'd11,5'd12,5'd13,5'd14,
    5'd15,5'd31,5'd16,5'd17,5'd18,5'd19,5'd6, 5'd2,
    5'd28,5'd27,5'd7, 5'd24,5'd29,5'd25,5'd23,5'd26
  };

  function automatic row_t pair_row(logic [4:0] x, logic [4:0] y);
    return {x, y[4:3]};
  endfunction

  function automatic bits_t pair_mask(logic [4:0] y);
    return 8'h80 >> y[2:0];
  endfunction

  function automatic logic alt_letter(logic [7:0] b);
    return ((b >= 8'h80) && (b < 8'hB0)) || ((b >= 8'hE0) && (b < 8'hF0));
  endfunction

  function automatic logic [4:0] alt_num(logic [7:0] b);
    logic [7:0] t;
    t = (b >= 8'hE0) ? (b - 8'h30) : b;
    return t[4:0];
  endfunction

endpackage

[sv/ccd_bitmap.sv]
// Seen-pair bitmap: 128 rows of 8 bits in a memory, one valid flop per row
// so a rearm clears the whole map at once. Depends on ccd_pkg.
module ccd_bitmap (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  ccd_pkg::row_t    rd_row_i,
  input  ccd_pkg::bmp_wr_t wr_i,
  input  logic             clr_i,
  output ccd_pkg::bits_t   rd_bits_o
);

  ccd_pkg::bits_t                 mem [ccd_pkg::RowsN];
  ccd_pkg::bits_t                 rd_data_q;
  ccd_pkg::row_t                  rd_row_q;
  logic [ccd_pkg::RowsN-1:0]      valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.row] <= wr_i.data;
    end
    if (rd_en_i) begin
      // bypass a write to the same row at this edge
      rd_data_q <= (wr_i.en && (wr_i.row == rd_row_i)) ? wr_i.data : mem[rd_row_i];
      rd_row_q  <= rd_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.row] <= 1'b1;
    end
  end

  // an unwritten row reads as nothing seen
  assign rd_bits_o = valid_q[rd_row_q] ? rd_data_q : '1;

endmodule

[sv/cyrillic_codepage_detector.sv]
// The ending byte passes the working register; its code is then registered on codepage_o.
// Throughput: one text byte per cycle; bitmap rows are read at the accept edge with a bypass of
//   the write at that edge; a code waiting on out_ready_i stalls the working register and input.
// Reset (rst_ni low, asynchronous): counters, previous byte and decided flag clear, every
//   bitmap row is marked unseen through its valid flop, byte_limit returns to 16384.
// Depends on ccd_pkg and ccd_bitmap.
module cyrillic_codepage_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // text byte channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  codepage_o,
  // configuration write channel (byte_limit)
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_byte_limit_i
);

  // Score each code page and pick the best; ties favor ALT, then WIN.
  function automatic ccd_pkg::cp_e verdict(logic [7:0] alt_inv, logic [7:0] alt_tot,
                                           logic [7:0] win_inv, logic [7:0] koi_inv,
                                           logic [7:0] up_tot);
    logic [7:0]  b1, b2, b3;
    logic [15:0] sa, sb, sc;
    b1 = (alt_inv <= (alt_tot >> 5)) ? 8'd0 : alt_inv;
    b2 = (win_inv <= (up_tot >> 5)) ? 8'd0 : win_inv;
    b3 = (koi_inv <= (up_tot >> 5)) ? 8'd0 : koi_inv;
    sa = {ccd_pkg::TotalMax - b1, alt_tot};
    sb = {ccd_pkg::TotalMax - b2, up_tot};
    sc = {ccd_pkg::TotalMax - b3, up_tot};
    if ((sa >= sb) && (sa >= sc)) return ccd_pkg::CpAlt;
    return (sb >= sc) ? ccd_pkg::CpWin : ccd_pkg::CpKoi;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration: always ready, take the write at once.
  // ---------------------------------------------------------------------------
  logic [15:0] byte_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q <= ccd_pkg::ByteLimitReset;
    end else if (cfg_valid_i) begin
      byte_limit_q <= cfg_byte_limit_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: hold the byte, track the previous byte, issue bitmap reads.
  // ---------------------------------------------------------------------------
  logic       in_fire;
  logic       s1_fire;
  logic       s1_valid_q;
  logic [7:0] prev_q;       // previous byte as seen by the next transaction
  logic [7:0] cur_q;        // byte in the working register
  logic [7:0] prv_q;        // its predecessor
  logic       eot_q;

  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // A zero byte or an end flag rearms, so the next byte has no predecessor.
  // When detection is already decided the next bytes are dropped, so the
  // previous byte only matters after a rearm.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        prev_q <= ((text_byte_i == 8'd0) || end_of_text_i) ? 8'd0 : text_byte_i;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_q <= text_byte_i;
      prv_q <= prev_q;
      eot_q <= end_of_text_i;
    end
  end

  ccd_pkg::row_t    alt_rd_row, win_rd_row;
  ccd_pkg::bits_t   alt_bits, win_bits;
  ccd_pkg::bmp_wr_t alt_wr, win_wr;
  logic             rearm;

  assign alt_rd_row = ccd_pkg::pair_row(ccd_pkg::alt_num(prev_q),
                                        ccd_pkg::alt_num(text_byte_i));
  assign win_rd_row = ccd_pkg::pair_row(prev_q[4:0], text_byte_i[4:0]);

  ccd_bitmap u_alt_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_row_i  (alt_rd_row),
    .wr_i      (alt_wr),
    .clr_i     (rearm),
    .rd_bits_o (alt_bits)
  );

  // The WIN map also stands for KOI8-R: same byte pairs, different letters.
  ccd_bitmap u_win_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_row_i  (win_rd_row),
    .wr_i      (win_wr),
    .clr_i     (rearm),
    .rd_bits_o (win_bits)
  );

  // ---------------------------------------------------------------------------
  // Working stage: classify the pair, update counts, decide.
  // ---------------------------------------------------------------------------
  logic [7:0]  alt_inv_q, alt_tot_q, win_inv_q, koi_inv_q, up_tot_q;
  logic [15:0] bytes_q;
  logic        decided_q;
  logic        out_valid_q;
  ccd_pkg::cp_e codepage_q;

  logic [7:0]  alt_inv_n, alt_tot_n, win_inv_n, koi_inv_n, up_tot_n;
  logic [15:0] bytes_n;
  logic        zero_byte, work, limit_hit, emit, set_dec;
  logic        alt_pair, alt_new, alt_bad;
  logic        win_pair, win_new, win_bad, koi_bad;
  logic [4:0]  alt_x, alt_y, koi_x, koi_y;
  ccd_pkg::row_t  alt_row, win_row, koi_row;
  ccd_pkg::bits_t alt_mask, win_mask, koi_mask;

  // Advance the working register whenever the result register can take a code.
  assign s1_fire = s1_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    zero_byte = (cur_q == 8'd0);
    work      = s1_fire && !decided_q && !zero_byte;

    alt_pair = ccd_pkg::alt_letter(prv_q) && ccd_pkg::alt_letter(cur_q);
    alt_x    = ccd_pkg::alt_num(prv_q);
    alt_y    = ccd_pkg::alt_num(cur_q);
    alt_row  = ccd_pkg::pair_row(alt_x, alt_y);
    alt_mask = ccd_pkg::pair_mask(alt_y);
    alt_new  = alt_pair && ((alt_bits & alt_mask) != '0);
    alt_bad  = (ccd_pkg::PairOk[alt_row] & alt_mask) == '0;

    // both bytes at 0xC0 and above
    win_pair = prv_q[7] && prv_q[6] && cur_q[7] && cur_q[6];
    win_row  = ccd_pkg::pair_row(prv_q[4:0], cur_q[4:0]);
    win_mask = ccd_pkg::pair_mask(cur_q[4:0]);
    win_new  = win_pair && ((win_bits & win_mask) != '0);
    win_bad  = (ccd_pkg::PairOk[win_row] & win_mask) == '0;

    koi_x    = ccd_pkg::KoiLetter[prv_q[4:0]];
    koi_y    = ccd_pkg::KoiLetter[cur_q[4:0]];
    koi_row  = ccd_pkg::pair_row(koi_x, koi_y);
    koi_mask = ccd_pkg::pair_mask(koi_y);
    koi_bad  = (ccd_pkg::PairOk[koi_row] & koi_mask) == '0;

    // updated counts; the pair counts equal the held ones when no pair is worked
    alt_inv_n = alt_inv_q + {7'd0, work && alt_new && alt_bad};
    alt_tot_n = alt_tot_q + {7'd0, work && alt_new};
    win_inv_n = win_inv_q + {7'd0, work && win_new && win_bad};
    koi_inv_n = koi_inv_q + {7'd0, work && win_new && koi_bad};
    up_tot_n  = up_tot_q  + {7'd0, work && win_new};
    bytes_n   = bytes_q + 16'd1;

    limit_hit = (bytes_n >= byte_limit_q) || (alt_tot_n == ccd_pkg::TotalMax) ||
                (up_tot_n == ccd_pkg::TotalMax);

    emit    = 1'b0;
    rearm   = 1'b0;
    set_dec = 1'b0;
    if (s1_fire) begin
      if (decided_q) begin
        // drop bytes until the text ends or a zero byte comes
        rearm = eot_q || zero_byte;
      end else if (zero_byte) begin
        emit  = 1'b1;
        rearm = 1'b1;
      end else begin
        emit    = eot_q || limit_hit;
        rearm   = eot_q;
        set_dec = !eot_q && limit_hit;
      end
    end

    alt_wr.en   = work && alt_new;
    alt_wr.row  = alt_row;
    alt_wr.data = alt_bits & ~alt_mask;
    win_wr.en   = work && win_new;
    win_wr.row  = win_row;
    win_wr.data = win_bits & ~win_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_inv_q <= '0;
      alt_tot_q <= '0;
      win_inv_q <= '0;
      koi_inv_q <= '0;
      up_tot_q  <= '0;
      bytes_q   <= '0;
      decided_q <= 1'b0;
    end else if (rearm) begin
      alt_inv_q <= '0;
      alt_tot_q <= '0;
      win_inv_q <= '0;
      koi_inv_q <= '0;
      up_tot_q  <= '0;
      bytes_q   <= '0;
      decided_q <= 1'b0;
    end else if (work) begin
      alt_inv_q <= alt_inv_n;
      alt_tot_q <= alt_tot_n;
      win_inv_q <= win_inv_n;
      koi_inv_q <= koi_inv_n;
      up_tot_q  <= up_tot_n;
      bytes_q   <= bytes_n;
      if (set_dec) begin
        decided_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold the code until the transaction completes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      codepage_q <= verdict(alt_inv_n, alt_tot_n, win_inv_n, koi_inv_n, up_tot_n);
    end
  end

  assign out_valid_o = out_valid_q;
  assign codepage_o  = codepage_q;

endmodule

[sv/ccd_checker.sv]
// Port-level checks for the Cyrillic code page detector, bound to its top level.
// Depends on ccd_pkg and cyrillic_codepage_detector.
module ccd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  codepage_o
);

  // a stalled code holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(codepage_o)))
    else $error("stalled code dropped or changed");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (codepage_o == ccd_pkg::CpAlt || codepage_o == ccd_pkg::CpWin ||
                     codepage_o == ccd_pkg::CpKoi))
    else $error("code out of range");

  // input backs up only behind a stalled result
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output stall");

  // a fresh code must be preceded by a taken byte, which passes the working register first
  a_code_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("code without a preceding byte");

endmodule

bind cyrillic_codepage_detector ccd_checker u_ccd_checker (.*);
